// File: hw/rtl/shapad_pkg.sv
// Shared types and constants for the SHA-256 message padder.
// Used by shapad_ctrl, shapad_dp and sha256_message_padder_top; no dependencies.
package shapad_pkg;

   // Width of the message byte counter; the bit count wraps at 2^(COUNT_BITS+3).
   localparam int COUNT_BITS   = 61;
   localparam int WORD_BITS    = 64;
   localparam int PART_BITS    = 56;
   localparam int PADDED_BITS  = 62;

   localparam logic [7:0] MARK_BYTE    = 8'h80;
   // Word slot within a 64-byte block that holds the length.
   localparam logic [2:0] LEN_SLOT     = 3'd7;
   // Word slot just before the length slot.
   localparam logic [2:0] PRE_LEN_SLOT = 3'd6;
   localparam logic [2:0] FULL_FILL    = 3'd7;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_MARK = 4'b0010,
      ST_ZERO = 4'b0100,
      ST_LEN  = 4'b1000
   } state_type;

   typedef struct packed {
      logic take;       // accept the item on the request ports
      logic emit_mark;  // emit the word holding the 0x80 marker
      logic emit_zero;  // emit an all-zero padding word
      logic emit_len;   // emit the length word and clear the message state
   } cmd_type;

   typedef struct packed {
      logic out_free;   // output register empty or being taken this cycle
      logic pre_len;    // next tail word sits just before the length slot
   } status_type;

endpackage

// File: hw/rtl/sha256_message_padder_top.sv
// SHA-256 message padder, top level.
// Depends on shapad_pkg, shapad_ctrl and shapad_dp.
// Usage:
//  - Request channel (req_*): one message byte per word. req_has_byte marks
//    req_data_byte as part of the message; req_last_byte ends the message.
//    A word with neither flag is dropped; req_last_byte alone ends the
//    message at its current length (an empty message if nothing came before).
//  - Response channel (rsp_*): big-endian 64-bit words of the padded message.
//    rsp_block_end flags the end of each 64-byte block; rsp_message_end flags
//    the final (length) word, which also carries rsp_padded_bytes.
//  - Latency: a byte that completes a word shows it on rsp_* the next cycle.
//  - Throughput: one byte per cycle while the response side keeps up; the
//    single output register takes a new word in the cycle its old one leaves.
//  - Padding tail: after the last word the block emits 2 to 9 tail words, one
//    per cycle unless stalled, and takes no request words until the length
//    word is loaded; the tail length is set by the word slot reached in the block.
//  - Stall: rsp_stall holds the output register; req_stall rises as long as
//    the output register is full and stalled, so nothing is lost.
//  - Reset (synchronous, active high): clears the byte count and partial
//    word, empties the output register and returns to accepting bytes.
module sha256_message_padder_top
   import shapad_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [7:0]             req_data_byte,
   input  logic                   req_has_byte,
   input  logic                   req_last_byte,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [WORD_BITS-1:0]   rsp_out_word,
   output logic                   rsp_block_end,
   output logic                   rsp_message_end,
   output logic [PADDED_BITS-1:0] rsp_padded_bytes
);

   cmd_type    cmd;
   status_type status;

   // Sequencer: decides when to take a byte and walks marker, zero and length words.
   shapad_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_last_byte (req_last_byte),
      .req_stall     (req_stall),
      .status        (status),
      .cmd           (cmd)
   );

   // Datapath: packs bytes, counts them and holds the output register.
   shapad_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_data_byte    (req_data_byte),
      .req_has_byte     (req_has_byte),
      .cmd              (cmd),
      .status           (status),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_word     (rsp_out_word),
      .rsp_block_end    (rsp_block_end),
      .rsp_message_end  (rsp_message_end),
      .rsp_padded_bytes (rsp_padded_bytes)
   );

endmodule

// File: hw/rtl/shapad_ctrl.sv
// Sequencer for the SHA-256 message padder: accepts words and walks the padding tail.
// Depends on shapad_pkg.
module shapad_ctrl
   import shapad_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_last_byte,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = !status.out_free;
            if (req_valid && status.out_free) begin
               cmd.take = 1'b1;
               if (req_last_byte) state_in = ST_MARK;
            end
         end
         ST_MARK: begin
            if (status.out_free) begin
               cmd.emit_mark = 1'b1;
               state_in = status.pre_len ? ST_LEN : ST_ZERO;
            end
         end
         ST_ZERO: begin
            if (status.out_free) begin
               cmd.emit_zero = 1'b1;
               if (status.pre_len) state_in = ST_LEN;
            end
         end
         ST_LEN: begin
            if (status.out_free) begin
               cmd.emit_len = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

endmodule

// File: hw/rtl/shapad_dp.sv
// Datapath of the SHA-256 message padder: byte packing, counters and output register.
// Depends on shapad_pkg; driven by commands from shapad_ctrl.
module shapad_dp
   import shapad_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic [7:0]             req_data_byte,
   input  logic                   req_has_byte,
   input  cmd_type                cmd,
   output status_type             status,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [WORD_BITS-1:0]   rsp_out_word,
   output logic                   rsp_block_end,
   output logic                   rsp_message_end,
   output logic [PADDED_BITS-1:0] rsp_padded_bytes
);

   logic [COUNT_BITS-1:0]  count_ff, count_in;
   logic [PART_BITS-1:0]   part_ff, part_in;
   logic [2:0]             fill_ff, fill_in;
   logic [2:0]             slot_ff, slot_in;
   logic                   valid_ff, valid_in;
   logic [WORD_BITS-1:0]   word_ff, word_in;
   logic                   blk_ff, blk_in;
   logic                   msg_ff, msg_in;
   logic [PADDED_BITS-1:0] padded_ff, padded_in;

   logic [COUNT_BITS-1:0]  count_inc;
   logic [2:0]             mark_sh;
   logic [WORD_BITS-1:0]   mark_word;
   logic [WORD_BITS-1:0]   len_word;
   logic [PADDED_BITS-1:0] count_ext;
   logic [PADDED_BITS-1:0] padded_total;

   assign count_inc = count_ff + COUNT_BITS'(1);
   // Place the held bytes first, then the marker, zeros after.
   assign mark_sh   = FULL_FILL - fill_ff;
   assign mark_word = {part_ff, MARK_BYTE} << {mark_sh, 3'b000};
   assign len_word  = WORD_BITS'(count_ff) << 3;
   // Round down to the block, add one block, or two if the length field does not fit.
   assign count_ext    = PADDED_BITS'(count_ff);
   assign padded_total = {count_ext[PADDED_BITS-1:6], 6'd0}
                         + ((count_ff[5:0] <= 6'd55) ? PADDED_BITS'(64) : PADDED_BITS'(128));

   assign status.out_free = !valid_ff || !rsp_stall;
   assign status.pre_len  = (slot_ff == PRE_LEN_SLOT);

   always_comb begin
      count_in  = count_ff;
      part_in   = part_ff;
      fill_in   = fill_ff;
      slot_in   = slot_ff;
      valid_in  = valid_ff && rsp_stall;
      word_in   = word_ff;
      blk_in    = blk_ff;
      msg_in    = msg_ff;
      padded_in = padded_ff;
      if (cmd.take) begin
         if (req_has_byte) begin
            count_in = count_inc;
            slot_in  = count_inc[5:3];
            if (fill_ff == FULL_FILL) begin
               word_in   = {part_ff, req_data_byte};
               blk_in    = (count_inc[5:0] == 6'd0);
               msg_in    = 1'b0;
               padded_in = '0;
               valid_in  = 1'b1;
               part_in   = '0;
               fill_in   = '0;
            end else begin
               part_in = {part_ff[PART_BITS-9:0], req_data_byte};
               fill_in = fill_ff + 3'd1;
            end
         end else begin
            slot_in = count_ff[5:3];
         end
      end
      if (cmd.emit_mark || cmd.emit_zero) begin
         word_in   = cmd.emit_mark ? mark_word : '0;
         blk_in    = (slot_ff == LEN_SLOT);
         msg_in    = 1'b0;
         padded_in = '0;
         valid_in  = 1'b1;
         part_in   = '0;
         fill_in   = '0;
         slot_in   = slot_ff + 3'd1;
      end
      if (cmd.emit_len) begin
         word_in   = len_word;
         blk_in    = 1'b1;
         msg_in    = 1'b1;
         padded_in = padded_total;
         valid_in  = 1'b1;
         count_in  = '0;
         part_in   = '0;
         fill_in   = '0;
         slot_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         part_ff  <= '0;
         fill_ff  <= '0;
         slot_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         part_ff  <= part_in;
         fill_ff  <= fill_in;
         slot_ff  <= slot_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff   <= word_in;
      blk_ff    <= blk_in;
      msg_ff    <= msg_in;
      padded_ff <= padded_in;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_out_word     = word_ff;
   assign rsp_block_end    = blk_ff;
   assign rsp_message_end  = msg_ff;
   assign rsp_padded_bytes = padded_ff;

endmodule

// File: dv/sha256_message_padder_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the SHA-256 message padder: predicts the padded words from
// accepted request words and checks each response word against them.
// Depends on shapad_pkg.
module sha256_message_padder_checker
   import shapad_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  logic [7:0]             req_data_byte,
   input  logic                   req_has_byte,
   input  logic                   req_last_byte,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  logic [WORD_BITS-1:0]   rsp_out_word,
   input  logic                   rsp_block_end,
   input  logic                   rsp_message_end,
   input  logic [PADDED_BITS-1:0] rsp_padded_bytes,
   output int                     mismatches,
   output int                     words_pending
);

   typedef struct packed {
      logic [WORD_BITS-1:0]   word;
      logic                   block_end;
      logic                   message_end;
      logic [PADDED_BITS-1:0] padded_bytes;
   } padded_word_type;

   padded_word_type words_due[$];

   // Message state as the block should hold it between words.
   logic [COUNT_BITS-1:0] msg_bytes  = '0;
   logic [PART_BITS-1:0]  held_bytes = '0;
   logic [2:0]            held_fill  = '0;

   // Word being packed while one request word is worked through.
   logic [WORD_BITS-1:0] pk_word = '0;
   int unsigned          pk_fill = 0;
   logic [5:0]           pk_pos  = '0;
   int                   bad_words = 0;

   // Append one byte to the padded stream; queue the word once it is full.
   task automatic pack_byte(input logic [7:0] b);
      pk_word = {pk_word[WORD_BITS-9:0], b};
      pk_fill++;
      pk_pos = pk_pos + 6'd1;
      if (pk_fill == 8) begin
         words_due.push_back(padded_word_type'{word: pk_word,
                                               block_end: (pk_pos == 6'd0),
                                               message_end: 1'b0, padded_bytes: '0});
         pk_word = '0;
         pk_fill = 0;
      end
   endtask

   always @(posedge clock) begin : watch
      logic [WORD_BITS-1:0]   bit_len;
      logic [PADDED_BITS-1:0] tail_len;
      padded_word_type        got;
      padded_word_type        want;
      int                     i;
      if (reset) begin
         msg_bytes  = '0;
         held_bytes = '0;
         held_fill  = '0;
         words_due.delete();
      end else begin
         if (req_valid && !req_stall) begin
            pk_word  = {8'h00, held_bytes};
            pk_fill  = held_fill;
            pk_pos   = msg_bytes[5:0];
            tail_len = '0;
            if (req_has_byte) begin
               msg_bytes = msg_bytes + 1'b1;
               pack_byte(req_data_byte);
            end
            if (!req_last_byte) begin
               held_bytes = pk_word[PART_BITS-1:0];
               held_fill  = pk_fill[2:0];
            end else begin
               // marker, zero fill up to the length slot, then the bit count
               pack_byte(MARK_BYTE);
               tail_len = 1;
               while (pk_pos != 6'd56) begin
                  pack_byte(8'h00);
                  tail_len = tail_len + 1'b1;
               end
               bit_len = WORD_BITS'(msg_bytes) << 3;
               for (i = 0; i < 8; i++) begin
                  pack_byte(bit_len[WORD_BITS-1-8*i -: 8]);
                  tail_len = tail_len + 1'b1;
               end
               want = words_due.pop_back();
               want.message_end  = 1'b1;
               want.padded_bytes = PADDED_BITS'(msg_bytes) + tail_len;
               words_due.push_back(want);
               msg_bytes  = '0;
               held_bytes = '0;
               held_fill  = '0;
            end
         end

         if (rsp_valid && !rsp_stall) begin
            got = padded_word_type'{rsp_out_word, rsp_block_end, rsp_message_end,
                                    rsp_padded_bytes};
            if (words_due.size() == 0) begin
               bad_words++;
               if (bad_words <= 10)
                  $display("%0t: unexpected word %h block_end %b message_end %b padded %0d",
                           $realtime, got.word, got.block_end, got.message_end,
                           got.padded_bytes);
            end else begin
               want = words_due.pop_front();
               if (got !== want) begin
                  bad_words++;
                  if (bad_words <= 10) begin
                     $display("%0t: word mismatch", $realtime);
                     $display("   expected %h block_end %b message_end %b padded %0d",
                              want.word, want.block_end, want.message_end,
                              want.padded_bytes);
                     $display("   actual   %h block_end %b message_end %b padded %0d",
                              got.word, got.block_end, got.message_end,
                              got.padded_bytes);
                  end
               end
            end
         end
      end
      words_pending <= words_due.size();
      mismatches    <= bad_words;
   end

endmodule

// File: dv/tb_sha256_message_padder_top.sv
`timescale 1ns / 1ps
// Testbench top for sha256_message_padder_top: sends messages byte by byte with
// random gaps and response stalls, and gives the verdict from the checker.
// Depends on shapad_pkg, sha256_message_padder_top and sha256_message_padder_checker.
module tb_sha256_message_padder_top;
   import shapad_pkg::*;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [7:0]             req_data_byte = 8'h00;
   logic                   req_has_byte = 1'b0;
   logic                   req_last_byte = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [WORD_BITS-1:0]   rsp_out_word;
   logic                   rsp_block_end;
   logic                   rsp_message_end;
   logic [PADDED_BITS-1:0] rsp_padded_bytes;

   int          mismatches;
   int          words_pending;
   int unsigned items_sent = 0;    // words carrying a byte or an end mark
   bit          quiet_end  = 1'b0; // no idling on either side once set
   bit          gaps_on    = 1'b1;
   bit          stalls_on  = 1'b1;
   int unsigned stall_left = 0;
   int unsigned stall_age  = 0;

   always #10 clock = ~clock;

   sha256_message_padder_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .req_has_byte     (req_has_byte),
      .req_last_byte    (req_last_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_word     (rsp_out_word),
      .rsp_block_end    (rsp_block_end),
      .rsp_message_end  (rsp_message_end),
      .rsp_padded_bytes (rsp_padded_bytes)
   );

   sha256_message_padder_checker padder_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .req_has_byte     (req_has_byte),
      .req_last_byte    (req_last_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_word     (rsp_out_word),
      .rsp_block_end    (rsp_block_end),
      .rsp_message_end  (rsp_message_end),
      .rsp_padded_bytes (rsp_padded_bytes),
      .mismatches       (mismatches),
      .words_pending    (words_pending)
   );

   // Response side: stall in bursts of random length. On a schedule kept by stall_age,
   // re-roll whether bursts may start at all, so calm stretches come up as well.
   always @(posedge clock) begin
      stall_age <= stall_age + 1;
      if (stall_age % 48 == 47)
         stalls_on <= ($urandom_range(0, 3) != 0);
      if (stall_left != 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (stalls_on && !quiet_end && $urandom_range(0, 3) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(0, 6);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Present one request word and hold it until it is taken. An optional gap
   // goes in front, so idle cycles land both mid-message and on padding tails.
   task automatic send_item(input logic [7:0] b, input logic has, input logic last);
      int unsigned gap;
      if (gaps_on && !quiet_end && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 7);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      req_has_byte  <= has;
      req_last_byte <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (has || last)
         items_sent++;
   endtask

   // One message of len bytes. The end comes either on the final byte or as a
   // bare end mark after it; an empty message is the bare end mark alone.
   // Sprinkle dropped words (neither flag) in between as noise.
   task automatic send_message(input int unsigned len);
      bit          split_tail;
      int unsigned k;
      split_tail = (len == 0) || ($urandom_range(0, 2) == 0);
      for (k = 0; k < len; k++) begin
         if ($urandom_range(0, 11) == 0)
            send_item(8'($urandom), 1'b0, 1'b0);
         send_item(8'($urandom), 1'b1, (k == len - 1) && !split_tail);
      end
      if (split_tail)
         send_item(8'($urandom), 1'b0, 1'b1);
   endtask

   // Drop valid and hold until the checker has nothing outstanding. The first
   // edge lets the checker's count catch up with the last accepted word.
   task automatic drain_words();
      int unsigned waited;
      waited = 0;
      req_valid <= 1'b0;
      @(posedge clock);
      while (words_pending != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
   endtask

   initial begin : stimulus
      logic [7:0]  pattern [8];
      int unsigned pick;
      int unsigned len;
      int          i;
      pattern = '{8'h80, 8'h7F, 8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01, 8'hFE};
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed part: empty message, a dropped word, one-byte messages ending
      // on the byte and on a bare end mark, then a message that fills exactly
      // one word and one that stops a byte short of it.
      send_item(8'h3C, 1'b0, 1'b1);
      send_item(8'hA5, 1'b0, 1'b0);
      send_item(8'hFF, 1'b1, 1'b1);
      send_item(8'h00, 1'b1, 1'b0);
      send_item(8'h5A, 1'b0, 1'b1);
      for (i = 0; i < 8; i++)
         send_item(pattern[i], 1'b1, i == 7);
      for (i = 0; i < 7; i++)
         send_item(~pattern[i], 1'b1, 1'b0);
      send_item(8'h00, 1'b0, 1'b1);

      // Hold the sender until every padded word has come out.
      drain_words();

      // Random part: mostly short messages, some medium, and some whose length
      // sits around the 55/56 byte point, where the tail spills into an extra
      // block, and around the 63/64 byte block boundary.
      while (items_sent < 280) begin
         if (items_sent >= 240)
            quiet_end <= 1'b1;
         if ($urandom_range(0, 5) == 0)
            gaps_on = ($urandom_range(0, 2) != 0);
         pick = $urandom_range(0, 9);
         if (pick < 7)
            len = $urandom_range(0, 12);
         else if (pick < 9)
            len = $urandom_range(13, 40);
         else
            len = ($urandom_range(0, 1) ? 54 : 62) + $urandom_range(0, 3);
         send_message(len);
      end

      drain_words();
      repeat (20) @(posedge clock);
      if (mismatches == 0 && words_pending == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #5_000_000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule

// File: sha256_message_padder_top.f
hw/rtl/shapad_pkg.sv
hw/rtl/shapad_ctrl.sv
hw/rtl/shapad_dp.sv
hw/rtl/sha256_message_padder_top.sv
dv/sha256_message_padder_checker.sv
dv/tb_sha256_message_padder_top.sv
